### hw/rtl/hrm_pkg.sv
package hrm_pkg;

  // Field widths of the channels.
  localparam int HALL_W   = 12;
  localparam int BG_W     = 12;
  localparam int MV_W     = 16;
  localparam int RPM_W    = 16;
  localparam int FREQ_W   = 10;
  localparam int TICKS_W  = 16;
  localparam int DET_W    = 2;
  localparam int WLOW_W   = 16;
  localparam int LEVEL_W  = 12;
  localparam int QUART_W  = 10;
  localparam int CFG_W    = 10;

  // Only the low SAMPLE_BITS bits of the hall sample take part.
  localparam int SAMPLE_BITS = 12;
  localparam logic [HALL_W-1:0] HALL_MASK =
    (SAMPLE_BITS >= HALL_W) ? {HALL_W{1'b1}} : HALL_W'((1 << SAMPLE_BITS) - 1);

  localparam int WINDOW_LOG2_DEF = 10;

  // Shared divider geometry.
  localparam int DIV_NUM_W = 23;
  localparam int DIV_DEN_W = 16;

  localparam logic [DIV_NUM_W-1:0] SUPPLY_NUM      = 23'd4963140;
  localparam logic [DIV_NUM_W-1:0] FREQ_NUM        = 23'd1000;
  localparam logic [BG_W-1:0]      BANDGAP_FLOOR   = 12'd100;
  localparam logic [TICKS_W-1:0]   COUNT_SAT       = 16'd65000;
  localparam logic [TICKS_W-1:0]   TICKS_VALID_MAX = 16'd60000;
  localparam logic [CFG_W-1:0]     MQS_RESET       = 10'd5;

  typedef enum logic [DET_W-1:0] {
    DET_IDLE      = 2'd0,
    DET_WAIT_HIGH = 2'd1,
    DET_WAIT_FALL = 2'd2,
    DET_WAIT_LOW  = 2'd3
  } det_state_t;

  typedef enum logic [1:0] {
    DIV_SUPPLY = 2'd0,
    DIV_FREQ   = 2'd1,
    DIV_RPM    = 2'd2
  } div_op_t;

  typedef enum logic [2:0] {
    S_IDLE       = 3'd0,
    S_SUP_START  = 3'd1,
    S_SUP_WAIT   = 3'd2,
    S_FREQ_START = 3'd3,
    S_FREQ_WAIT  = 3'd4,
    S_RPM_START  = 3'd5,
    S_RPM_WAIT   = 3'd6,
    S_COMMIT     = 3'd7
  } ctrl_state_t;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    div_op_t div_op;
    logic    commit;
  } hrm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rev_valid;
    logic out_free;
  } hrm_status_t;

endpackage

### hw/rtl/hrm_in_if.sv
interface hrm_in_if import hrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALL_W-1:0] hall_sample;
  logic [BG_W-1:0]   bandgap_sample;

  modport source (output valid, output hall_sample, output bandgap_sample, input ready);
  modport sink   (input valid, input hall_sample, input bandgap_sample, output ready);
endinterface

### hw/rtl/hrm_out_if.sv
interface hrm_out_if import hrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MV_W-1:0]    supply_mv;
  logic [RPM_W-1:0]   speed_rpm;
  logic [FREQ_W-1:0]  frequency_hz;
  logic [TICKS_W-1:0] ticks_per_revolution;
  logic [DET_W-1:0]   detector_state;
  logic [WLOW_W-1:0]  window_low;
  logic [LEVEL_W-1:0] window_high;
  logic [LEVEL_W-1:0] window_mid;
  logic [LEVEL_W-1:0] window_swing;
  logic               revolution_done;

  modport source (
    output valid, output supply_mv, output speed_rpm, output frequency_hz,
    output ticks_per_revolution, output detector_state, output window_low,
    output window_high, output window_mid, output window_swing,
    output revolution_done, input ready
  );
  modport sink (
    input valid, input supply_mv, input speed_rpm, input frequency_hz,
    input ticks_per_revolution, input detector_state, input window_low,
    input window_high, input window_mid, input window_swing,
    input revolution_done, output ready
  );
endinterface

### hw/rtl/hrm_div.sv
module hrm_div import hrm_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] work;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle; the quotient shifts into the numerator word.
  always_comb begin
    trial = {rem, work[NUM_W-1]};
    fits  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
        rem   <= '0;
        work  <= num;
      end else if (busy) begin
        rem   <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        work  <= {work[NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = work;

endmodule

### hw/rtl/hrm_ctrl.sv
module hrm_ctrl import hrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hrm_status_t status,
  output hrm_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_SUP_START;
      S_SUP_START:  state_next = S_SUP_WAIT;
      S_SUP_WAIT: begin
        if (status.div_done) begin
          state_next = status.rev_valid ? S_FREQ_START : S_COMMIT;
        end
      end
      S_FREQ_START: state_next = S_FREQ_WAIT;
      S_FREQ_WAIT:  if (status.div_done) state_next = S_RPM_START;
      S_RPM_START:  state_next = S_RPM_WAIT;
      S_RPM_WAIT:   if (status.div_done) state_next = S_COMMIT;
      S_COMMIT:     if (status.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_op    = DIV_SUPPLY;
    cmd.commit    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_SUP_START:  cmd.div_start = 1'b1;
      S_SUP_WAIT:   cmd.div_op = DIV_SUPPLY;
      S_FREQ_START: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_FREQ;
      end
      S_FREQ_WAIT:  cmd.div_op = DIV_FREQ;
      S_RPM_START: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_RPM;
      end
      S_RPM_WAIT:   cmd.div_op = DIV_RPM;
      S_COMMIT:     cmd.commit = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/hrm_dp.sv
module hrm_dp import hrm_pkg::*; #(
  parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hrm_cmd_t          cmd,
  output hrm_status_t       status,
  input  logic [HALL_W-1:0] hall_sample,
  input  logic [BG_W-1:0]   bandgap_sample,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  hrm_out_if.source         results
);

  // Captured item.
  logic [HALL_W-1:0] hall_q;
  logic [BG_W-1:0]   bg_q;

  // Architectural state.
  logic [CFG_W-1:0]       min_quarter_swing;
  logic [WINDOW_LOG2-1:0] tick_phase;
  logic [WLOW_W-1:0]      running_low;
  logic [LEVEL_W-1:0]     running_high;
  logic [WLOW_W-1:0]      held_low;
  logic [LEVEL_W-1:0]     held_high;
  logic [LEVEL_W-1:0]     mid_level;
  logic [LEVEL_W-1:0]     swing;
  logic [QUART_W-1:0]     quarter_swing;
  det_state_t             phase_state;
  logic [TICKS_W-1:0]     tick_counter;
  logic [TICKS_W-1:0]     latched_ticks;
  logic [FREQ_W-1:0]      latched_freq;
  logic [RPM_W-1:0]       latched_rpm;
  logic [MV_W-1:0]        latched_supply;

  logic out_valid;

  // Per-item update terms.
  logic [WLOW_W-1:0]      run_low_upd;
  logic [LEVEL_W-1:0]     run_high_upd;
  logic [TICKS_W-1:0]     cnt_inc;
  logic [LEVEL_W:0]       thr_high;
  logic [LEVEL_W+1:0]     thr_low;
  logic                   low_hit;
  logic                   crossing;
  logic                   ticks_ok;
  det_state_t             det_next;
  logic [WINDOW_LOG2-1:0] tick_phase_next;
  logic                   win;
  logic [WLOW_W:0]        level_sum;
  logic [WLOW_W-1:0]      swing_full;
  logic [QUART_W-1:0]     quarter_raw;
  logic                   low_swing;

  // Values after this item.
  logic [WLOW_W-1:0]  running_low_next;
  logic [LEVEL_W-1:0] running_high_next;
  logic [WLOW_W-1:0]  held_low_next;
  logic [LEVEL_W-1:0] held_high_next;
  logic [LEVEL_W-1:0] mid_level_next;
  logic [LEVEL_W-1:0] swing_next;
  logic [QUART_W-1:0] quarter_swing_next;
  det_state_t         phase_state_next;
  logic [TICKS_W-1:0] tick_counter_next;
  logic [TICKS_W-1:0] latched_ticks_next;
  logic [FREQ_W-1:0]  latched_freq_next;
  logic [RPM_W-1:0]   latched_rpm_next;

  // Divider.
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  always_comb begin
    case (cmd.div_op)
      DIV_SUPPLY: begin
        div_num = SUPPLY_NUM;
        div_den = DIV_DEN_W'(bg_q);
      end
      DIV_FREQ: begin
        div_num = FREQ_NUM;
        div_den = DIV_DEN_W'(cnt_inc);
      end
      DIV_RPM: begin
        div_num = DIV_NUM_W'(TICKS_VALID_MAX);
        div_den = DIV_DEN_W'(cnt_inc);
      end
      default: begin
        div_num = SUPPLY_NUM;
        div_den = DIV_DEN_W'(bg_q);
      end
    endcase
  end

  hrm_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Running extremes, tick count and detector.
  always_comb begin
    run_low_upd  = (running_low > WLOW_W'(hall_q)) ? WLOW_W'(hall_q) : running_low;
    run_high_upd = (running_high < hall_q) ? hall_q : running_high;
    cnt_inc      = (tick_counter < COUNT_SAT) ? tick_counter + 1'b1 : tick_counter;

    thr_high = {1'b0, mid_level} + (LEVEL_W+1)'(quarter_swing);
    // The low threshold may go negative, and then it is never reached.
    thr_low  = (LEVEL_W+2)'(mid_level) - (LEVEL_W+2)'(quarter_swing);
    low_hit  = !thr_low[LEVEL_W+1] && ((LEVEL_W+1)'(hall_q) <= thr_low[LEVEL_W:0]);

    crossing = 1'b0;
    det_next = phase_state;
    case (phase_state)
      DET_WAIT_HIGH: if ((LEVEL_W+1)'(hall_q) > thr_high) det_next = DET_WAIT_FALL;
      DET_WAIT_FALL: if ((LEVEL_W+1)'(hall_q) <= thr_high) det_next = DET_WAIT_LOW;
      DET_WAIT_LOW: begin
        if (low_hit) begin
          crossing = 1'b1;
          det_next = DET_WAIT_HIGH;
        end
      end
      default: det_next = phase_state;
    endcase
    ticks_ok = (cnt_inc != '0) && (cnt_inc <= TICKS_VALID_MAX);
  end

  // Window update at the end of the item.
  always_comb begin
    tick_phase_next = tick_phase + 1'b1;
    win             = &tick_phase_next;
    level_sum       = {1'b0, run_low_upd} + (WLOW_W+1)'(run_high_upd);
    swing_full      = WLOW_W'(run_high_upd) - run_low_upd;
    quarter_raw     = QUART_W'(swing_full[WLOW_W-1:2]);
    low_swing       = quarter_raw < min_quarter_swing;

    running_low_next   = win ? {WLOW_W{1'b1}} : run_low_upd;
    running_high_next  = win ? '0 : run_high_upd;
    held_low_next      = win ? run_low_upd : held_low;
    held_high_next     = win ? run_high_upd : held_high;
    mid_level_next     = win ? level_sum[LEVEL_W:1] : mid_level;
    swing_next         = win ? swing_full[LEVEL_W-1:0] : swing;
    quarter_swing_next = quarter_swing;
    phase_state_next   = det_next;
    tick_counter_next  = crossing ? '0 : cnt_inc;
    latched_ticks_next = crossing ? cnt_inc : latched_ticks;
    latched_freq_next  = latched_freq;
    latched_rpm_next   = (crossing && !ticks_ok) ? '0 : latched_rpm;

    if (win) begin
      if (low_swing) begin
        latched_freq_next = '0;
        latched_rpm_next  = '0;
        phase_state_next  = DET_IDLE;
        quarter_swing_next = quarter_raw;
      end else begin
        quarter_swing_next = (quarter_raw == '0) ? QUART_W'(1) : quarter_raw;
        if (det_next == DET_IDLE) phase_state_next = DET_WAIT_HIGH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hall_q <= hall_sample & HALL_MASK;
      bg_q   <= (bandgap_sample < BANDGAP_FLOOR) ? BANDGAP_FLOOR : bandgap_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_quarter_swing <= MQS_RESET;
      tick_phase        <= '0;
      running_low       <= {WLOW_W{1'b1}};
      running_high      <= '0;
      held_low          <= {WLOW_W{1'b1}};
      held_high         <= '0;
      mid_level         <= '0;
      swing             <= '0;
      quarter_swing     <= '0;
      phase_state       <= DET_IDLE;
      tick_counter      <= '0;
      latched_ticks     <= '0;
      latched_freq      <= '0;
      latched_rpm       <= '0;
      latched_supply    <= '0;
    end else begin
      if (cfg_we) begin
        min_quarter_swing <= cfg_data;
      end
      if (div_done) begin
        case (cmd.div_op)
          DIV_SUPPLY: latched_supply <= div_quo[MV_W-1:0];
          DIV_FREQ:   latched_freq   <= div_quo[FREQ_W-1:0];
          DIV_RPM:    latched_rpm    <= div_quo[RPM_W-1:0];
          default:    latched_supply <= div_quo[MV_W-1:0];
        endcase
      end
      if (cmd.commit) begin
        tick_phase    <= tick_phase_next;
        running_low   <= running_low_next;
        running_high  <= running_high_next;
        held_low      <= held_low_next;
        held_high     <= held_high_next;
        mid_level     <= mid_level_next;
        swing         <= swing_next;
        quarter_swing <= quarter_swing_next;
        phase_state   <= phase_state_next;
        tick_counter  <= tick_counter_next;
        latched_ticks <= latched_ticks_next;
        latched_freq  <= latched_freq_next;
        latched_rpm   <= latched_rpm_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      results.supply_mv            <= latched_supply;
      results.speed_rpm            <= latched_rpm_next;
      results.frequency_hz         <= latched_freq_next;
      results.ticks_per_revolution <= latched_ticks_next;
      results.detector_state       <= phase_state_next;
      results.window_low           <= held_low_next;
      results.window_high          <= held_high_next;
      results.window_mid           <= mid_level_next;
      results.window_swing         <= swing_next;
      results.revolution_done      <= crossing;
    end
  end

  assign results.valid = out_valid;

  assign status.div_done  = div_done;
  assign status.rev_valid = crossing && ticks_ok;
  assign status.out_free  = !out_valid || results.ready;

endmodule

### hw/rtl/hall_rpm_meter_top.sv
// Hall sensor speed meter.
// Each item on the samples channel is one 1 ms tick with a hall sample and a
// bandgap sample. For every item the block returns exactly one item on the
// results channel: supply voltage, latched rpm, frequency, ticks per
// revolution, detector state, the held window levels and a revolution flag.
// The threshold min_quarter_swing is written through cfg_we and cfg_data; the
// user must do so only while no item is in flight, which the block does not enforce.
// An item goes through the supply division and, on a tick that completes
// a valid revolution, the frequency and rpm divisions before its result;
// the next item can be accepted in the cycle its result appears. The work
// runs through one shared restoring divider of 23 steps, used once for the
// supply and twice more on such a tick. One item is worked on at a time.
// The result sits in an output register, so the next item is accepted while
// an earlier result still waits; if the receiver stalls, the following item
// waits in its final step until the register frees up.
// Reset clears all detector and window state and sets the threshold to 5.
module hall_rpm_meter_top import hrm_pkg::*; #(
  parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  hrm_in_if.sink           samples,
  hrm_out_if.source        results
);

  hrm_cmd_t    cmd;
  hrm_status_t status;
  logic        in_ready;

  hrm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  hrm_dp #(
    .WINDOW_LOG2(WINDOW_LOG2)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .hall_sample   (samples.hall_sample),
    .bandgap_sample(samples.bandgap_sample),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .results       (results)
  );

  assign samples.ready = in_ready;

endmodule

### verif/hall_rpm_meter_top_tb.sv
module hall_rpm_meter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrm_pkg::*;

  typedef struct packed {
    logic [HALL_W-1:0] hall;
    logic [BG_W-1:0]   bandgap;
  } tick_sample_t;

  typedef struct packed {
    logic [MV_W-1:0]    supply_mv;
    logic [RPM_W-1:0]   speed_rpm;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [TICKS_W-1:0] ticks_per_revolution;
    logic [DET_W-1:0]   detector_state;
    logic [WLOW_W-1:0]  window_low;
    logic [LEVEL_W-1:0] window_high;
    logic [LEVEL_W-1:0] window_mid;
    logic [LEVEL_W-1:0] window_swing;
    logic               revolution_done;
  } meter_reading_t;

  localparam int WIN_LOG2 = WINDOW_LOG2_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [HALL_W-1:0] in_hall = '0;
  logic [BG_W-1:0] in_bandgap = '0;
  logic out_ready = 1'b0;

  hrm_in_if  samples_if ();
  hrm_out_if results_if ();

  assign samples_if.valid          = in_valid;
  assign samples_if.hall_sample    = in_hall;
  assign samples_if.bandgap_sample = in_bandgap;
  assign results_if.ready          = out_ready;

  hall_rpm_meter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .samples  (samples_if),
    .results  (results_if)
  );

  always #5 clk = ~clk;

  // Meter state as the block should hold it.
  logic [CFG_W-1:0]    m_min_quarter = MQS_RESET;
  logic [WIN_LOG2-1:0] m_phase = '0;
  logic [WLOW_W-1:0]   m_run_low = '1;
  logic [LEVEL_W-1:0]  m_run_high = '0;
  logic [WLOW_W-1:0]   m_held_low = '1;
  logic [LEVEL_W-1:0]  m_held_high = '0;
  logic [LEVEL_W-1:0]  m_mid = '0;
  logic [LEVEL_W-1:0]  m_swing = '0;
  logic [QUART_W-1:0]  m_quarter = '0;
  det_state_t          m_state = DET_IDLE;
  logic [TICKS_W-1:0]  m_count = '0;
  logic [TICKS_W-1:0]  m_ticks = '0;
  logic [FREQ_W-1:0]   m_freq = '0;
  logic [RPM_W-1:0]    m_rpm = '0;
  logic [MV_W-1:0]     m_supply = '0;

  tick_sample_t   pending_ticks[$];
  meter_reading_t expected_readings[$];

  int  ticks_queued = 0;
  int  ticks_accepted = 0;
  int  readings_checked = 0;
  int  revolutions = 0;
  int  windows = 0;
  int  settings_used = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  hold_gap = 0;
  bit  quiet_tail = 1'b0;

  function automatic meter_reading_t advance_meter(logic [HALL_W-1:0] hall_raw,
                                                   logic [BG_W-1:0] bg_raw);
    meter_reading_t r;
    logic [HALL_W-1:0] hall;
    logic [BG_W-1:0] bg;
    logic done;
    hall = hall_raw & HALL_MASK;
    bg = (bg_raw < BANDGAP_FLOOR) ? BANDGAP_FLOOR : bg_raw;
    m_supply = MV_W'(int'(SUPPLY_NUM) / int'(bg));

    if (m_run_low > WLOW_W'(hall)) m_run_low = WLOW_W'(hall);
    if (m_run_high < hall) m_run_high = hall;
    if (m_count < COUNT_SAT) m_count = m_count + 1'b1;

    done = 1'b0;
    case (m_state)
      DET_WAIT_HIGH: begin
        if (int'(hall) > int'(m_mid) + int'(m_quarter)) m_state = DET_WAIT_FALL;
      end
      DET_WAIT_FALL: begin
        if (int'(hall) <= int'(m_mid) + int'(m_quarter)) m_state = DET_WAIT_LOW;
      end
      DET_WAIT_LOW: begin
        // The low threshold may go negative, and then it is never crossed.
        if (int'(hall) <= int'(m_mid) - int'(m_quarter)) begin
          m_ticks = m_count;
          if (m_ticks != 0 && m_ticks <= TICKS_VALID_MAX) begin
            m_freq = FREQ_W'(int'(FREQ_NUM) / int'(m_ticks));
            m_rpm  = RPM_W'(int'(TICKS_VALID_MAX) / int'(m_ticks));
          end else begin
            m_rpm = '0;
          end
          m_count = '0;
          m_state = DET_WAIT_HIGH;
          done = 1'b1;
          revolutions++;
        end
      end
      default: begin
      end
    endcase

    m_phase = m_phase + 1'b1;
    if (&m_phase) begin
      m_held_low  = m_run_low;
      m_held_high = m_run_high;
      m_run_low   = '1;
      m_run_high  = '0;
      m_mid       = LEVEL_W'((int'(m_held_high) + int'(m_held_low)) / 2);
      m_swing     = LEVEL_W'(int'(m_held_high) - int'(m_held_low));
      m_quarter   = QUART_W'(m_swing >> 2);
      if (m_quarter < m_min_quarter) begin
        m_freq  = '0;
        m_rpm   = '0;
        m_state = DET_IDLE;
      end else begin
        if (m_quarter == '0) m_quarter = QUART_W'(1);
        if (m_state == DET_IDLE) m_state = DET_WAIT_HIGH;
      end
      windows++;
    end

    r.supply_mv            = m_supply;
    r.speed_rpm            = m_rpm;
    r.frequency_hz         = m_freq;
    r.ticks_per_revolution = m_ticks;
    r.detector_state       = m_state;
    r.window_low           = m_held_low;
    r.window_high          = m_held_high;
    r.window_mid           = m_mid;
    r.window_swing         = m_swing;
    r.revolution_done      = done;
    return r;
  endfunction

  function automatic void flag(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  function automatic void check_reading();
    meter_reading_t want;
    if (expected_readings.size() == 0) begin
      flag("result with nothing pending, supply_mv", 0, results_if.supply_mv);
      return;
    end
    want = expected_readings.pop_front();
    if (results_if.supply_mv !== want.supply_mv)
      flag("supply_mv", want.supply_mv, results_if.supply_mv);
    if (results_if.speed_rpm !== want.speed_rpm)
      flag("speed_rpm", want.speed_rpm, results_if.speed_rpm);
    if (results_if.frequency_hz !== want.frequency_hz)
      flag("frequency_hz", want.frequency_hz, results_if.frequency_hz);
    if (results_if.ticks_per_revolution !== want.ticks_per_revolution)
      flag("ticks_per_revolution", want.ticks_per_revolution,
           results_if.ticks_per_revolution);
    if (results_if.detector_state !== want.detector_state)
      flag("detector_state", want.detector_state, results_if.detector_state);
    if (results_if.window_low !== want.window_low)
      flag("window_low", want.window_low, results_if.window_low);
    if (results_if.window_high !== want.window_high)
      flag("window_high", want.window_high, results_if.window_high);
    if (results_if.window_mid !== want.window_mid)
      flag("window_mid", want.window_mid, results_if.window_mid);
    if (results_if.window_swing !== want.window_swing)
      flag("window_swing", want.window_swing, results_if.window_swing);
    if (results_if.revolution_done !== want.revolution_done)
      flag("revolution_done", want.revolution_done, results_if.revolution_done);
    readings_checked++;
  endfunction

  // Sample driver: one item per handshake, with random gaps between items.
  always @(posedge clk) begin
    tick_sample_t next_tick;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && samples_if.ready) begin
        expected_readings.push_back(advance_meter(in_hall, in_bandgap));
        ticks_accepted++;
      end
      if (!in_valid || samples_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          next_tick = pending_ticks.pop_front();
          in_valid   <= 1'b1;
          in_hall    <= next_tick.hall;
          in_bandgap <= next_tick.bandgap;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (results_if.valid && out_ready) check_reading();
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        hold_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_tick(logic [HALL_W-1:0] hall, logic [BG_W-1:0] bandgap);
    tick_sample_t t;
    t.hall = hall;
    t.bandgap = bandgap;
    pending_ticks.push_back(t);
    ticks_queued++;
  endfunction

  function automatic logic [BG_W-1:0] pick_bandgap();
    case ($urandom_range(0, 9))
      0: return BG_W'($urandom_range(0, 99));
      1: return BG_W'($urandom_range(100, 200));
      default: return BG_W'($urandom);
    endcase
  endfunction

  // Square-ish rotation: a few high samples, then at least two low ones,
  // so that every period can complete a revolution. Levels stay below the
  // top code so that a later window can still come out weak.
  function automatic void queue_rotation(int upto);
    int period;
    int high_len;
    logic [HALL_W-1:0] hall;
    while (ticks_queued < upto) begin
      period = $urandom_range(3, 40);
      high_len = $urandom_range(1, period - 2);
      for (int i = 0; i < period && ticks_queued < upto; i++) begin
        if ($urandom_range(0, 19) == 0) hall = HALL_W'($urandom_range(0, 4000));
        else if (i < high_len) hall = HALL_W'($urandom_range(3200, 4000));
        else hall = HALL_W'($urandom_range(0, 900));
        queue_tick(hall, pick_bandgap());
      end
    end
  endfunction

  function automatic void queue_flat(int upto);
    while (ticks_queued < upto)
      queue_tick(HALL_W'($urandom_range(0, 1)), pick_bandgap());
  endfunction

  function automatic void queue_noise(int upto);
    while (ticks_queued < upto) begin
      if ($urandom_range(0, 1) == 0) queue_tick(HALL_W'($urandom_range(0, 3)), pick_bandgap());
      else queue_tick(HALL_W'($urandom), pick_bandgap());
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  task automatic set_threshold(logic [CFG_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_min_quarter = value;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, alternating bit patterns and the bandgap floor.
    set_threshold(MQS_RESET);
    queue_tick(12'd0, 12'd0);
    queue_tick(12'hFFF, 12'hFFF);
    queue_tick(12'hAAA, 12'd99);
    queue_tick(12'h555, 12'd100);
    queue_tick(12'd1, 12'd101);
    queue_tick(12'h800, 12'd1);
    queue_tick(12'hFFE, 12'hAAA);
    queue_tick(12'h800, 12'h555);
    queue_tick(12'h7FF, 12'd1212);
    queue_tick(12'd3, 12'h800);
    queue_tick(12'hFFE, 12'hFFE);
    queue_tick(12'h001, 12'h7FF);

    // The first window arms the detector; revolutions follow.
    queue_rotation(1100);

    set_threshold(CFG_W'($urandom_range(1, 1022)));
    quiet_tail = 1'b1;
    queue_rotation(1200);
    queue_flat(1220);
    queue_noise(1250);

    wait_drained();
    repeat (100) @(posedge clk);

    $display("Checked %0d ticks: %0d revolutions, %0d window updates.",
             readings_checked, revolutions, windows);
    $display("Threshold was written %0d times; %0d field mismatches.",
             settings_used, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0 &&
        ticks_accepted == ticks_queued) begin
      $display("** hall_rpm_meter_top: PASSED **");
    end else begin
      $display("** hall_rpm_meter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d ticks accepted.", ticks_accepted);
    $display("** hall_rpm_meter_top: FAILED **");
    $finish;
  end

endmodule
